// ===== rtl/drlpf_pkg.sv =====
// package: constants, tables and types for the dual rgb led pattern fader
`default_nettype none
package drlpf_pkg;
	localparam int TICKS_PER_BEAT_DEF = 1;
	localparam int NUM_LEDS_DEF = 2;
	localparam int FADE_LEN = 11;
	localparam int FRAC_BITS = 4;
	localparam int LVL_W = 7;

	localparam logic [2:0] COL_OFF = 3'd0;
	localparam logic [2:0] COL_GREEN = 3'd2;
	localparam logic [2:0] COL_WHITE = 3'd4;

	typedef enum logic [1:0] {
		MODE_DOWN = 2'd0,
		MODE_UP   = 2'd1,
		MODE_DONE = 2'd2
	} mode_t;

	typedef struct packed {
		logic [LVL_W-1:0] r;
		logic [LVL_W-1:0] g;
		logic [LVL_W-1:0] b;
	} rgb_t;

	function automatic rgb_t color_level(input logic [2:0] col);
		rgb_t v;
		v = '0;
		case (col)
			3'd1: v.r = 7'd80;
			3'd2: v.g = 7'd80;
			3'd3: v.b = 7'd80;
			3'd4: v = '{7'd100, 7'd100, 7'd100};
			3'd5: v.r = 7'd40;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] white_fade(input logic [3:0] i);
		logic [7:0] v;
		case (i)
			4'd0: v = 8'd0;
			4'd1: v = 8'd4;
			4'd2: v = 8'd9;
			4'd3: v = 8'd16;
			4'd4: v = 8'd24;
			4'd5: v = 8'd33;
			4'd6: v = 8'd44;
			4'd7: v = 8'd56;
			4'd8: v = 8'd69;
			4'd9: v = 8'd84;
			4'd10: v = 8'd100;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

	// colors of phase 0 and 1
	function automatic logic [5:0] pat_cols(input logic [2:0] p);
		logic [5:0] v;
		case (p)
			3'd1: v = {3'd2, 3'd2};
			3'd2: v = {3'd2, 3'd4};
			3'd3: v = {3'd4, 3'd4};
			3'd4: v = {3'd1, 3'd4};
			3'd5: v = {3'd1, 3'd1};
			3'd6: v = {3'd5, 3'd1};
			3'd7: v = {3'd0, 3'd1};
			default: v = '0;
		endcase
		return v;
	endfunction

	// beats of phase 0 and 1
	function automatic logic [5:0] pat_lens(input logic [2:0] p);
		logic [5:0] v;
		case (p)
			3'd2, 3'd4: v = {3'd4, 3'd2};
			3'd6: v = {3'd4, 3'd4};
			3'd7: v = {3'd5, 3'd1};
			default: v = '0;
		endcase
		return v;
	endfunction

	// tap length in half tap units: 2, 5 or 7
	function automatic logic [2:0] pat_tap_halves(input logic [2:0] p);
		logic [2:0] v;
		case (p)
			3'd6: v = 3'd5;
			3'd7: v = 3'd7;
			default: v = 3'd2;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/dual_rgb_led_pattern_fader.sv =====
// top level: dual rgb led pattern fader with shared sequencer
// a tick with no color change gives only its one final transaction, with m_tlast set
// a color change fills the fade table of each changed led, then emits one transaction per fade step
// one tick at a time: ready only while the sequencer is idle, which output stalls prolong
// all state resets asynchronously on arst_n low; the fade table has no reset
`default_nettype none
module dual_rgb_led_pattern_fader #(
	parameter int TICKS_PER_BEAT = drlpf_pkg::TICKS_PER_BEAT_DEF,
	parameter int NUM_LEDS = drlpf_pkg::NUM_LEDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// desired_left[2:0], desired_right[5:3], tap[6], side[8:7], zero fill
	input  wire logic [15:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// left_red, left_green, left_blue, right_red, right_green, right_blue, 7 bits each
	output logic [47:0]      m_tdata,
	output logic             m_tlast
);
	import drlpf_pkg::*;
	localparam int TAP_UNIT = TICKS_PER_BEAT * 8;
	localparam int PT_W = $clog2(TICKS_PER_BEAT * 8 + 1);
	localparam int TC_W = $clog2(TAP_UNIT * 3 + TAP_UNIT / 2 + 1);
	localparam int NL = NUM_LEDS;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SEL, ST_BUILD, ST_ITER_RD, ST_ITER_WAIT, ST_ITER_UPD,
		ST_EMIT, ST_FINAL, ST_FWAIT
	} state_t;

	state_t state_q;
	logic [2:0] want_q [NL];
	logic tap_q;
	logic [1:0] cs_q;
	logic [PT_W-1:0] pt_q [NL];
	logic [2:0] pat_q [NL];
	logic [TC_W-1:0] tc_q [NL];
	logic [2:0] shown_q [NL];
	mode_t mode_q [NL];
	logic [3:0] idx_q [NL];
	rgb_t cur_q [NL];
	logic led_q;
	logic [3:0] cnt_q;
	logic [10:0] acc_q;
	logic [7:0] start_q, delta_q;
	logic white_q;
	logic [3:0] n_q;
	logic moved_q;

	logic tbl_we;
	logic [7:0] tbl_wdata, tbl_rdata;

	drlpf_tbl u_tbl (
		.clk(clk), .we(tbl_we), .wled(led_q), .waddr(cnt_q), .wdata(tbl_wdata),
		.rled(led_q), .raddr(idx_q[led_q]), .rdata(tbl_rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign tbl_we = (state_q == ST_BUILD);
	assign tbl_wdata = white_q ? white_fade(cnt_q) :
		8'(start_q + 8'((acc_q + 11'd8) >> FRAC_BITS));

	// current color of a led from its pattern and phase
	function automatic logic [2:0] phase_col(input logic [2:0] p, input logic [PT_W-1:0] pt);
		logic [5:0] cl, ln;
		cl = pat_cols(p);
		ln = pat_lens(p);
		return (32'(pt) < TICKS_PER_BEAT * int'(ln[2:0])) ? cl[2:0] : cl[5:3];
	endfunction

	rgb_t tgt, frm, nxt;
	logic [2:0] newcol;
	logic mv;
	logic [7:0] lv;
	logic [6:0] a_ch, b_ch, tot;
	logic up;
	always_comb begin
		newcol = phase_col(pat_q[led_q], pt_q[led_q]);
		frm = color_level(shown_q[led_q]);
		tgt = color_level(newcol);
		up = (frm.r < tgt.r) || (frm.g < tgt.g) || (frm.b < tgt.b);
		if (shown_q[led_q] == COL_GREEN || newcol == COL_GREEN) begin
			a_ch = frm.g; b_ch = tgt.g;
		end else begin
			a_ch = frm.r; b_ch = tgt.r;
		end
		tot = (a_ch > b_ch) ? a_ch - b_ch : b_ch - a_ch;
		// iteration target uses shown color
		lv = tbl_rdata;
		nxt = cur_q[led_q];
		mv = 1'b0;
		tgt = (state_q == ST_SEL) ? tgt : color_level(shown_q[led_q]);
		if (mode_q[led_q] == MODE_DOWN) begin
			if (nxt.r > tgt.r && {1'b0, nxt.r} >= lv) begin
				nxt.r = (lv > {1'b0, tgt.r}) ? lv[6:0] : tgt.r; mv = 1'b1;
			end
			if (nxt.g > tgt.g && {1'b0, nxt.g} >= lv) begin
				nxt.g = (lv > {1'b0, tgt.g}) ? lv[6:0] : tgt.g; mv = 1'b1;
			end
			if (nxt.b > tgt.b && {1'b0, nxt.b} >= lv) begin
				nxt.b = (lv > {1'b0, tgt.b}) ? lv[6:0] : tgt.b; mv = 1'b1;
			end
		end else begin
			if (nxt.r < tgt.r && {1'b0, nxt.r} <= lv) begin
				nxt.r = (lv < {1'b0, tgt.r}) ? lv[6:0] : tgt.r; mv = 1'b1;
			end
			if (nxt.g < tgt.g && {1'b0, nxt.g} <= lv) begin
				nxt.g = (lv < {1'b0, tgt.g}) ? lv[6:0] : tgt.g; mv = 1'b1;
			end
			if (nxt.b < tgt.b && {1'b0, nxt.b} <= lv) begin
				nxt.b = (lv < {1'b0, tgt.b}) ? lv[6:0] : tgt.b; mv = 1'b1;
			end
		end
	end

	// delta = total*16/10 via multiply by reciprocal, small range
	logic [10:0] t16;
	logic [7:0] dlt;
	always_comb begin
		t16 = {tot, 4'd0};
		dlt = 8'((22'(t16) * 22'd1639) >> 14);
		if (11'(dlt) * 11'd10 > t16)
			dlt = dlt - 8'd1;
	end

	logic any_busy;
	assign any_busy = (mode_q[0] != MODE_DONE) || (mode_q[NL-1] != MODE_DONE);

	logic [3:0] lens_sum;
	logic [5:0] ln_c;
	always_comb begin
		ln_c = pat_lens(pat_q[led_q]);
		lens_sum = 4'(ln_c[2:0]) + 4'(ln_c[5:3]);
	end

	rgb_t lvl_l, lvl_r;
	assign lvl_l = color_level(shown_q[0]);
	assign lvl_r = color_level(shown_q[NL-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
			m_tlast <= 1'b0;
			m_tdata <= '0;
			for (int i = 0; i < NL; i++) begin
				pt_q[i] <= '0; pat_q[i] <= '0; tc_q[i] <= '0; shown_q[i] <= COL_OFF;
				mode_q[i] <= MODE_DONE; cur_q[i] <= '0; idx_q[i] <= '0;
				want_q[i] <= '0;
			end
			tap_q <= 1'b0; cs_q <= '0; led_q <= 1'b0; cnt_q <= '0; acc_q <= '0;
			start_q <= '0; delta_q <= '0; white_q <= 1'b0; n_q <= '0; moved_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						want_q[0] <= s_tdata[2:0];
						want_q[NL-1] <= s_tdata[5:3];
						tap_q <= s_tdata[6];
						cs_q <= s_tdata[8:7];
						led_q <= 1'b0;
						n_q <= '0;
						moved_q <= 1'b0;
						state_q <= ST_SEL;
						cnt_q <= '0;
					end
				end
				ST_SEL: begin
					// pattern take, done in pass cnt_q==0, color check in pass 1
					if (cnt_q == 4'd0) begin
						if (want_q[led_q] != pat_q[led_q] &&
							({1'b0, led_q} == cs_q || tc_q[led_q] == '0)) begin
							pt_q[led_q] <= '0;
							tc_q[led_q] <= tap_q ?
								TC_W'(int'(pat_tap_halves(want_q[led_q])) * TAP_UNIT / 2) : '0;
							pat_q[led_q] <= want_q[led_q];
						end
						cnt_q <= 4'd1;
					end else if (shown_q[led_q] != newcol) begin
						cur_q[led_q] <= frm;
						mode_q[led_q] <= up ? MODE_UP : MODE_DOWN;
						idx_q[led_q] <= up ? 4'd1 : 4'(FADE_LEN - 2);
						white_q <= (shown_q[led_q] == COL_WHITE) || (newcol == COL_WHITE);
						start_q <= {1'b0, up ? a_ch : b_ch};
						delta_q <= dlt;
						acc_q <= '0;
						shown_q[led_q] <= newcol;
						moved_q <= 1'b1;
						cnt_q <= '0;
						state_q <= ST_BUILD;
					end else if (led_q == 1'b0) begin
						led_q <= 1'b1; cnt_q <= '0;
					end else begin
						led_q <= 1'b0;
						state_q <= moved_q ? ST_ITER_RD : ST_FINAL;
					end
				end
				ST_BUILD: begin
					acc_q <= acc_q + 11'(delta_q);
					if (cnt_q == 4'(FADE_LEN - 1)) begin
						cnt_q <= '0;
						if (led_q == 1'b0) begin
							led_q <= 1'b1;
							state_q <= ST_SEL;
						end else begin
							led_q <= 1'b0;
							state_q <= ST_ITER_RD;
						end
					end else
						cnt_q <= cnt_q + 4'd1;
				end
				ST_ITER_RD: begin
					if (n_q == 4'(FADE_LEN - 1) || !any_busy)
						state_q <= ST_FINAL;
					else if (mode_q[led_q] == MODE_DONE)
						state_q <= ST_ITER_UPD;
					else
						state_q <= ST_ITER_WAIT;
				end
				ST_ITER_WAIT: state_q <= ST_ITER_UPD;
				ST_ITER_UPD: begin
					if (mode_q[led_q] != MODE_DONE) begin
						cur_q[led_q] <= nxt;
						if (!mv)
							mode_q[led_q] <= MODE_DONE;
						else if (mode_q[led_q] == MODE_DOWN) begin
							if (idx_q[led_q] == 4'd0)
								mode_q[led_q] <= MODE_DONE;
							else
								idx_q[led_q] <= idx_q[led_q] - 4'd1;
						end else begin
							if (idx_q[led_q] == 4'(FADE_LEN - 1))
								mode_q[led_q] <= MODE_DONE;
							else
								idx_q[led_q] <= idx_q[led_q] + 4'd1;
						end
					end
					if (led_q == 1'b0) begin
						led_q <= 1'b1;
						state_q <= ST_ITER_WAIT;
					end else begin
						led_q <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!m_tvalid) begin
						m_tdata <= {6'd0, cur_q[NL-1].b, cur_q[NL-1].g, cur_q[NL-1].r,
							cur_q[0].b, cur_q[0].g, cur_q[0].r};
						m_tlast <= 1'b0;
						m_tvalid <= 1'b1;
						n_q <= n_q + 4'd1;
						state_q <= ST_ITER_RD;
					end
				end
				ST_FINAL: begin
					if (!m_tvalid) begin
						mode_q[0] <= MODE_DONE;
						mode_q[NL-1] <= MODE_DONE;
						m_tdata <= {6'd0, lvl_r.b, lvl_r.g, lvl_r.r,
							lvl_l.b, lvl_l.g, lvl_l.r};
						m_tlast <= 1'b1;
						m_tvalid <= 1'b1;
						state_q <= ST_FWAIT;
					end
				end
				ST_FWAIT: begin
					if (ln_c[2:0] != 3'd0) begin
						if (32'(pt_q[led_q]) + 1 == TICKS_PER_BEAT * int'(lens_sum))
							pt_q[led_q] <= '0;
						else
							pt_q[led_q] <= pt_q[led_q] + PT_W'(1);
					end
					if (tc_q[led_q] != '0)
						tc_q[led_q] <= tc_q[led_q] - TC_W'(1);
					if (led_q == 1'b0)
						led_q <= 1'b1;
					else begin
						led_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/drlpf_tbl.sv =====
// fade table memory, one row per led
`default_nettype none
module drlpf_tbl (
	input  wire logic       clk,
	input  wire logic       we,
	input  wire logic       wled,
	input  wire logic [3:0] waddr,
	input  wire logic [7:0] wdata,
	input  wire logic       rled,
	input  wire logic [3:0] raddr,
	output logic      [7:0] rdata
);
	import drlpf_pkg::*;
	logic [7:0] mem [0:2*FADE_LEN-1];
	always_ff @(posedge clk) begin
		if (we)
			mem[5'(wled) * 5'(FADE_LEN) + 5'(waddr)] <= wdata;
		rdata <= mem[5'(rled) * 5'(FADE_LEN) + 5'(raddr)];
	end
endmodule
`default_nettype wire

// ===== rtl/drlpf_chk.sv =====
// port checker for the dual rgb led pattern fader, with bind
`default_nettype none
module drlpf_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        m_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after a transaction");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:0] <= 7'd100 && m_tdata[27:21] <= 7'd100)
		else $error("level above 100");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tlast)
		else $error("idle with fade step pending");
endmodule

bind dual_rgb_led_pattern_fader drlpf_chk u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

// ===== sim/dual_rgb_led_pattern_fader_checker.sv =====
// checker: predicts the led level transactions of the pattern fader and compares them
`default_nettype none
module dual_rgb_led_pattern_fader_checker
	import drlpf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [15:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [47:0] m_tdata,
	input  wire logic        m_tlast,
	output int               fail_count,
	output int               pending,
	output int               level_count
);
	localparam int BEAT = TICKS_PER_BEAT_DEF;
	localparam int TAP_UNIT = BEAT * 8;

	typedef struct packed {
		logic        last;
		logic [47:0] levels;
	} level_rec_t;

	level_rec_t levels_due[$];

	int    phase_ticks [2];
	int    active_pat [2];
	int    tap_count [2];
	int    shown [2];
	mode_t fmode [2];
	int    fidx [2];
	int    cur [6];
	int    ftab [2][11];

	function automatic int lvl_of(input int col, input int ch);
		int v;
		v = 0;
		case (col)
			1: v = (ch == 0) ? 80 : 0;
			2: v = (ch == 1) ? 80 : 0;
			3: v = (ch == 2) ? 80 : 0;
			4: v = 100;
			5: v = (ch == 0) ? 40 : 0;
			default: v = 0;
		endcase
		return v;
	endfunction

	function automatic int phase_col(input int p, input int ph);
		int c0, c1;
		c0 = 0;
		c1 = 0;
		case (p)
			1: begin c0 = 2; c1 = 2; end
			2: begin c0 = 4; c1 = 2; end
			3: begin c0 = 4; c1 = 4; end
			4: begin c0 = 4; c1 = 1; end
			5: begin c0 = 1; c1 = 1; end
			6: begin c0 = 1; c1 = 5; end
			7: begin c0 = 1; c1 = 0; end
			default: ;
		endcase
		return ph ? c1 : c0;
	endfunction

	function automatic int phase_len(input int p, input int ph);
		int l0, l1;
		l0 = 0;
		l1 = 0;
		case (p)
			2, 4: begin l0 = 2; l1 = 4; end
			6: begin l0 = 4; l1 = 4; end
			7: begin l0 = 1; l1 = 5; end
			default: ;
		endcase
		return ph ? l1 : l0;
	endfunction

	function automatic int tap_len(input int p);
		if (p == 6)
			return TAP_UNIT * 2 + TAP_UNIT / 2;
		if (p == 7)
			return TAP_UNIT * 3 + TAP_UNIT / 2;
		return TAP_UNIT;
	endfunction

	function automatic int white_step(input int i);
		int t [11];
		t = '{0, 4, 9, 16, 24, 33, 44, 56, 69, 84, 100};
		return t[i];
	endfunction

	task automatic build_fade(input int s, input int from, input int to);
		bit up;
		int ch, a, b, start, total, delta, acc;
		up = 0;
		for (int c = 0; c < 3; c++) begin
			cur[s*3+c] = lvl_of(from, c);
			if (cur[s*3+c] < lvl_of(to, c))
				up = 1;
		end
		fmode[s] = up ? MODE_UP : MODE_DOWN;
		fidx[s] = up ? 1 : 9;
		if (from == COL_WHITE || to == COL_WHITE) begin
			for (int i = 0; i < 11; i++)
				ftab[s][i] = white_step(i);
		end else begin
			ch = (from == COL_GREEN || to == COL_GREEN) ? 1 : 0;
			a = cur[s*3+ch];
			b = lvl_of(to, ch);
			start = up ? a : b;
			total = a > b ? a - b : b - a;
			delta = (total << FRAC_BITS) / 10;
			acc = 0;
			for (int i = 0; i < 11; i++) begin
				ftab[s][i] = (start + ((acc + 8) >> FRAC_BITS)) & 8'hff;
				acc += delta;
			end
		end
	endtask

	task automatic fade_step(input int s);
		int lvl, tg;
		bit moved;
		moved = 0;
		if (fidx[s] < 0 || fidx[s] > 10) begin
			fmode[s] = MODE_DONE;
			return;
		end
		lvl = ftab[s][fidx[s]];
		for (int c = 0; c < 3; c++) begin
			tg = lvl_of(shown[s], c);
			if (fmode[s] == MODE_DOWN && cur[s*3+c] > tg && cur[s*3+c] >= lvl) begin
				cur[s*3+c] = lvl > tg ? lvl : tg;
				moved = 1;
			end else if (fmode[s] == MODE_UP && cur[s*3+c] < tg && cur[s*3+c] <= lvl) begin
				cur[s*3+c] = lvl < tg ? lvl : tg;
				moved = 1;
			end
		end
		if (fmode[s] == MODE_DOWN) begin
			fidx[s]--;
			if (!moved || fidx[s] < 0)
				fmode[s] = MODE_DONE;
		end else if (fmode[s] == MODE_UP) begin
			fidx[s]++;
			if (!moved || fidx[s] > 10)
				fmode[s] = MODE_DONE;
		end
	endtask

	task automatic predict_tick(input logic [15:0] d);
		int want [2];
		int tap, side, n, col;
		bit change;
		level_rec_t r;
		want[0] = int'(d[2:0]);
		want[1] = int'(d[5:3]);
		tap = int'(d[6]);
		side = int'(d[8:7]);
		change = 0;
		n = 0;
		for (int i = 0; i < 2; i++) begin
			if (want[i] != active_pat[i] && (i == side || tap_count[i] == 0)) begin
				phase_ticks[i] = 0;
				tap_count[i] = tap ? tap_len(want[i]) : 0;
				active_pat[i] = want[i];
			end
			col = phase_col(active_pat[i],
				(phase_ticks[i] < BEAT * phase_len(active_pat[i], 0)) ? 0 : 1);
			if (shown[i] != col) begin
				build_fade(i, shown[i], col);
				shown[i] = col;
				change = 1;
			end
		end
		if (change) begin
			while (n < 10 && (fmode[0] != MODE_DONE || fmode[1] != MODE_DONE)) begin
				for (int i = 0; i < 2; i++)
					if (fmode[i] != MODE_DONE)
						fade_step(i);
				r.last = 0;
				for (int c = 0; c < 6; c++)
					r.levels[c*7 +: 7] = cur[c][6:0];
				levels_due.push_back(r);
				n++;
			end
			fmode[0] = MODE_DONE;
			fmode[1] = MODE_DONE;
		end
		r.last = 1;
		for (int i = 0; i < 2; i++) begin
			for (int c = 0; c < 3; c++)
				r.levels[(i*3+c)*7 +: 7] = 7'(lvl_of(shown[i], c));
			if (phase_len(active_pat[i], 0) != 0) begin
				phase_ticks[i]++;
				if (phase_ticks[i] == BEAT * (phase_len(active_pat[i], 0)
						+ phase_len(active_pat[i], 1)))
					phase_ticks[i] = 0;
			end
			if (tap_count[i] != 0)
				tap_count[i]--;
		end
		levels_due.push_back(r);
	endtask

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	always @(posedge clk) begin
		level_rec_t e;
		if (!arst_n) begin
			fail_count = 0;
			level_count = 0;
			levels_due.delete();
			for (int i = 0; i < 2; i++) begin
				phase_ticks[i] = 0;
				active_pat[i] = 0;
				tap_count[i] = 0;
				shown[i] = 0;
				fmode[i] = MODE_DONE;
				fidx[i] = 0;
			end
			for (int c = 0; c < 6; c++)
				cur[c] = 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_tick(s_tdata);
			if (m_tvalid && m_tready) begin
				level_count++;
				if (levels_due.size() == 0) begin
					report("transaction with nothing expected");
				end else begin
					e = levels_due.pop_front();
					for (int c = 0; c < 6; c++)
						if (m_tdata[c*7 +: 7] !== e.levels[c*7 +: 7])
							report($sformatf("channel %0d got %0d want %0d", c,
								m_tdata[c*7 +: 7], e.levels[c*7 +: 7]));
					if (m_tlast !== e.last)
						report($sformatf("tlast got %b want %b", m_tlast, e.last));
				end
			end
		end
		pending = levels_due.size();
	end
endmodule
`default_nettype wire

// ===== sim/dual_rgb_led_pattern_fader_test.sv =====
// testbench top: stimulus, idling and verdict for the dual rgb led pattern fader
`default_nettype none
module dual_rgb_led_pattern_fader_test;
	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tlast;
	int          fail_count, pending, level_count;
	int          send_idle_pct, recv_idle_pct;
	int          hold_cycles;
	int          hold_req, hold_seen;
	int          quiet_cycles;
	int          tick_count;

	localparam int WATCHDOG = 20000;
	localparam int HOLD_LEN = 400;

	dual_rgb_led_pattern_fader u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	dual_rgb_led_pattern_fader_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fail_count(fail_count), .pending(pending), .level_count(level_count)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	// receiver: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_cycles <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_cycles <= HOLD_LEN;
			m_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if (s_tvalid && s_tready || m_tvalid && m_tready)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("watchdog expired with %0d transactions expected", pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic send_tick(input logic [2:0] left, input logic [2:0] right,
			input logic tap, input logic [1:0] side);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {7'd0, side, tap, right, left};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tick_count++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic send_random(input int count);
		logic [2:0] l, r;
		int k;
		k = 0;
		while (k < count) begin
			// mostly hold a pattern for several ticks so phases run through
			l = 3'($urandom_range(7));
			r = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : l;
			repeat ($urandom_range(4, 1))
				if (k < count) begin
					send_tick(l, r, 1'($urandom_range(1)), 2'($urandom_range(3)));
					k++;
				end
		end
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		hold_req = 0;
		tick_count = 0;
		send_idle_pct = 18;
		recv_idle_pct = 57;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: every pattern on each side, tap, each charge side
		for (int p = 0; p < 8; p++)
			send_tick(3'(p), 3'(7 - p), 1'b0, 2'd2);
		send_tick(3'd6, 3'd7, 1'b1, 2'd0);
		send_tick(3'd1, 3'd5, 1'b1, 2'd3);
		send_tick(3'd2, 3'd4, 1'b1, 2'd1);
		send_tick(3'd0, 3'd3, 1'b0, 2'd0);
		send_tick(3'd5, 3'd1, 1'b0, 2'd1);
		for (int k = 0; k < 6; k++)
			send_tick(3'd7, 3'd6, 1'b0, 2'd2);
		send_tick(3'd7, 3'd6, 1'b1, 2'd3);
		send_tick(3'd0, 3'd0, 1'b0, 2'd2);

		// sender pauses until every transaction has come
		drain();
		send_random(45);

		// long receiver hold-off while ticks keep coming
		hold_req++;
		send_idle_pct = 57;
		recv_idle_pct = 18;
		send_random(50);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(34);

		drain();
		repeat (100) @(posedge clk);
		$display("run covered %0d ticks and %0d led level transactions",
			tick_count, level_count);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire
